/* rtl/core/query_string_url_decoder_unit_defines.svh */
// Assertion macros for the query string decoder RTL.
// Included by modules that check their own control logic; no other dependencies.
`ifndef QUERY_STRING_URL_DECODER_UNIT_DEFINES_SVH
`define QUERY_STRING_URL_DECODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, reset masks the check.
`define QSUD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qsud check failed");
// Next-cycle implication, reset masks the check.
`define QSUD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qsud check failed");
`else
`define QSUD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define QSUD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/qsud_pkg.sv */
// Shared types, character codes and the hex digit helper for the query decoder.
// No dependencies.
`default_nettype none
package qsud_pkg;

  localparam int unsigned MAX_RES   = 4;
  localparam int unsigned RES_CNT_W = 3;

  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_t;

  // Parser state carried from word to word
  typedef struct packed {
    logic       in_value;
    logic       key_seen;
    esc_t       escape_phase;
    logic [7:0] held;
  } st_t;

  // One result word
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       keep;
    logic       done;
    logic       last;
  } res_t;

  typedef res_t [MAX_RES-1:0] res_list_t;

  // {ok, nibble}; ok only for 0-9, A-F, a-f
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [7:0] t;
    t = 8'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      t = b - 8'h30;
      return {1'b1, t[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      t = b - 8'h37;
      return {1'b1, t[3:0]};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      t = b - 8'h57;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/query_string_url_decoder_unit.sv */
// Top level of the query string decoder: input register, step logic, result queue.
// Depends on qsud_pkg, qsud_step and query_string_url_decoder_unit_defines.svh.
//
// Usage:
//   The input stream carries the query string one byte per word: in_tdata is
//   the raw byte, in_tlast marks the last byte, in_tuser is the byte-valid flag
//   (0 only on the lone end-mark word of an empty string).
//   The result stream gives decoded key bytes, value bytes and pair ends; the
//   kind sits in out_tuser and out_tlast marks the last result of one input word.
//   The first result of a word reaches the output after the word passes the
//   input register and then the result queue head; a queue that is not yet
//   drained holds the word in the input register until it can be loaded.
//   Throughput: one input word per cycle while each word yields at most one
//   result and out_tready stays high; a word that yields more (at most four,
//   from a broken escape or a pair end) holds the input side while the single
//   output port drains the result queue one entry per cycle of out_tready.
//   Words yielding no result ('=' switch, first half of an escape) still pass
//   through the input register one at a time.
//   Reset (synchronous, rst_n low) empties both stages and returns the parser
//   to the key part with no escape pending.
//   When the receiver stalls, the queue and then the input register fill and
//   in_tready drops; nothing is lost or reordered.
`default_nettype none
`include "query_string_url_decoder_unit_defines.svh"
module query_string_url_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_string
  input  logic        in_tuser,   // byte_valid
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [8] keep_pair, [9] string_done
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast   // last_of_run
);
  import qsud_pkg::*;

  // Input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;
  logic       in_bv_r;

  // Parser state and result queue
  st_t                  st_r;
  st_t                  st_nxt;
  res_list_t            q_r;
  logic [RES_CNT_W-1:0] cnt_r;
  res_list_t            step_res;
  logic [RES_CNT_W-1:0] step_cnt;

  logic pop;
  logic load;
  logic in_acc;

  assign pop    = (cnt_r != '0) && out_tready;
  assign load   = in_vld_r && ((cnt_r == '0) || ((cnt_r == RES_CNT_W'(1)) && out_tready));
  assign in_tready = !in_vld_r || load;
  assign in_acc = in_tvalid && in_tready;

  qsud_step u_step (
    .st_cur     (st_r),
    .data_byte  (in_byte_r),
    .at_end     (in_end_r),
    .byte_valid (in_bv_r),
    .st_nxt     (st_nxt),
    .res        (step_res),
    .res_cnt    (step_cnt)
  );

  // Input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (load) begin
      in_vld_r <= 1'b0;
    end
  end

  // Input payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tlast;
      in_bv_r   <= in_tuser;
    end
  end

  // Parser state advances when a word is decoded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (load) begin
      st_r <= st_nxt;
    end
  end

  // Result queue fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= step_cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Result queue payload: entry 0 is the output register
  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= step_res;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        q_r[i] <= q_r[i+1];
      end
    end
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {6'd0, q_r[0].done, q_r[0].keep, q_r[0].data};
  assign out_tuser  = q_r[0].kind;
  assign out_tlast  = q_r[0].last;

  // Checks
  `QSUD_ASSERT_NOW(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= RES_CNT_W'(MAX_RES))
  `QSUD_ASSERT_NOW(a_load_drained, clk, rst_n, load,
                   (cnt_r == '0) || ((cnt_r == RES_CNT_W'(1)) && out_tready))
  `QSUD_ASSERT_NEXT(a_end_resets, clk, rst_n, load && in_end_r,
                    !st_r.in_value && !st_r.key_seen && (st_r.escape_phase == ESC_NONE))
  `QSUD_ASSERT_NOW(a_last_on_tail, clk, rst_n, out_tvalid && (cnt_r == RES_CNT_W'(1)),
                   out_tlast)
  `QSUD_ASSERT_NOW(a_no_early_last, clk, rst_n, out_tvalid && (cnt_r > RES_CNT_W'(1)),
                   !out_tlast)

endmodule
`default_nettype wire

/* rtl/core/qsud_step.sv */
// Combinational step of the query decoder: one input word to up to four results.
// Depends on qsud_pkg.
`default_nettype none
module qsud_step (
  input  qsud_pkg::st_t      st_cur,
  input  logic [7:0]         data_byte,
  input  logic               at_end,
  input  logic               byte_valid,
  output qsud_pkg::st_t      st_nxt,
  output qsud_pkg::res_list_t res,
  output logic [qsud_pkg::RES_CNT_W-1:0] res_cnt
);
  import qsud_pkg::*;

  logic [4:0] hex_b;
  logic [4:0] hex_h;
  logic       emit_pct;
  logic       emit_held;
  logic       emit_dec;
  logic       do_plain;
  logic       pct_open;
  logic       iv;
  logic       ks;
  esc_t       ph_n;
  logic [7:0] held_n;
  logic [RES_CNT_W-1:0] n;
  logic [RES_CNT_W-1:0] n_last;

  function automatic res_t char_res(input logic val, input logic [7:0] c);
    res_t r;
    r.kind = val ? KIND_VALUE : KIND_KEY;
    r.data = c;
    r.keep = 1'b0;
    r.done = 1'b0;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic res_t end_res(input logic keep, input logic done);
    res_t r;
    r.kind = KIND_END;
    r.data = 8'd0;
    r.keep = keep;
    r.done = done;
    r.last = 1'b0;
    return r;
  endfunction

  assign hex_b = hex_nibble(data_byte);
  assign hex_h = hex_nibble(st_cur.held);

  // Escape handling: decide which pieces this word emits
  always_comb begin
    emit_pct  = 1'b0;
    emit_held = 1'b0;
    emit_dec  = 1'b0;
    do_plain  = 1'b0;
    ph_n      = ESC_NONE;
    held_n    = st_cur.held;
    if (!byte_valid) begin
      if (at_end) begin
        emit_pct  = (st_cur.escape_phase != ESC_NONE);
        emit_held = (st_cur.escape_phase == ESC_DIGIT);
      end else begin
        ph_n = st_cur.escape_phase;
      end
    end else begin
      unique case (st_cur.escape_phase)
        ESC_PCT: begin
          if (hex_b[4] && !at_end) begin
            ph_n   = ESC_DIGIT;
            held_n = data_byte;
          end else begin
            emit_pct = 1'b1;
            do_plain = 1'b1;
          end
        end
        ESC_DIGIT: begin
          if (hex_b[4]) begin
            emit_dec = 1'b1;
          end else begin
            emit_pct  = 1'b1;
            emit_held = 1'b1;
            do_plain  = 1'b1;
          end
        end
        default: begin
          do_plain = 1'b1;
        end
      endcase
    end
  end

  // Build the result list in model order
  always_comb begin
    res      = '0;
    n        = '0;
    iv       = st_cur.in_value;
    ks       = st_cur.key_seen;
    n_last   = '0;
    pct_open = 1'b0;
    if (emit_pct) begin
      res[n[1:0]] = char_res(iv, CH_PCT);
      ks = ks | ~iv;
      n  = n + 1'b1;
    end
    if (emit_held) begin
      res[n[1:0]] = char_res(iv, st_cur.held);
      ks = ks | ~iv;
      n  = n + 1'b1;
    end
    if (emit_dec) begin
      res[n[1:0]] = char_res(iv, {hex_h[3:0], hex_b[3:0]});
      ks = ks | ~iv;
      n  = n + 1'b1;
    end
    if (do_plain) begin
      priority if (data_byte == CH_EQ && !iv) begin
        iv = 1'b1;
      end else if (data_byte == CH_AMP) begin
        res[n[1:0]] = end_res(ks, 1'b0);
        n  = n + 1'b1;
        iv = 1'b0;
        ks = 1'b0;
      end else if (data_byte == CH_PLUS) begin
        res[n[1:0]] = char_res(iv, CH_SPACE);
        ks = ks | ~iv;
        n  = n + 1'b1;
      end else if (data_byte == CH_PCT && !at_end) begin
        // a plain '%' opens an escape (only outside the end of string)
        pct_open = 1'b1;
      end else begin
        res[n[1:0]] = char_res(iv, data_byte);
        ks = ks | ~iv;
        n  = n + 1'b1;
      end
    end
    // End of string closes the final pair
    if (at_end) begin
      res[n[1:0]] = end_res(ks, 1'b1);
      n = n + 1'b1;
    end
    if (n != '0) begin
      n_last = n - 1'b1;
      res[n_last[1:0]].last = 1'b1;
    end
  end

  // Next state: the end of string returns everything to reset
  always_comb begin
    st_nxt = st_cur;
    if (at_end) begin
      st_nxt = '0;
    end else begin
      st_nxt.in_value     = iv;
      st_nxt.key_seen     = ks;
      st_nxt.escape_phase = pct_open ? ESC_PCT : ph_n;
      st_nxt.held         = held_n;
    end
  end

  assign res_cnt = n;

endmodule
`default_nettype wire
